>>> sv/sat_pkg.sv
// ----------------------------------------------------------------------------
// Section address translator package
// Shared constants, command codes and structs for the translator modules.
// ----------------------------------------------------------------------------
package sat_pkg;

    // Section table sizing
    localparam int SECT_MAX = 16;
    localparam int IDX_W    = (SECT_MAX > 1) ? $clog2(SECT_MAX) : 1;
    localparam int CNT_W    = $clog2(SECT_MAX + 1);
    localparam logic [CNT_W-1:0] SECT_MAX_CNT = CNT_W'(SECT_MAX);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_IMAGE_BASE   = 2'd0;
    localparam logic [1:0] REG_PROCESS_BASE = 2'd1;
    localparam logic [1:0] REG_USE_PROCESS  = 2'd2;

    // Request commands
    localparam logic [3:0] CMD_CLEAR        = 4'd0;
    localparam logic [3:0] CMD_APPEND       = 4'd1;
    localparam logic [3:0] CMD_VA_TO_OFFSET = 4'd2;
    localparam logic [3:0] CMD_VA_TO_ADDR   = 4'd3;
    localparam logic [3:0] CMD_ADDR_TO_VA   = 4'd4;
    localparam logic [3:0] CMD_VA_TO_ABS    = 4'd5;
    localparam logic [3:0] CMD_ABS_TO_VA    = 4'd6;
    localparam logic [3:0] CMD_ABS_TO_ADDR  = 4'd7;
    localparam logic [3:0] CMD_ADDR_TO_ABS  = 4'd8;

    // One section table row
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] file_pos;
        logic [31:0] image_size;
        logic [31:0] raw_size;
        logic [31:0] load_addr;
    } sect_row_t;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [31:0] image_base;
        logic [31:0] process_base;
        logic        use_process_base;
    } cfg_t;

    // Shared adder: operands and result
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        ge;
    } alu_rsp_t;

endpackage

>>> sv/sat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sat_alu.sv
// ----------------------------------------------------------------------------
// Shared adder / comparator
// One 32-bit add or subtract per cycle; on subtract also gives a >= b.
// ----------------------------------------------------------------------------
module sat_alu (
    input  sat_pkg::alu_req_t req,
    output sat_pkg::alu_rsp_t rsp
);
    import sat_pkg::*;

    logic [32:0] wide;

    // a + b, or a + ~b + 1; carry out of the subtract means no borrow
    always_comb
    begin
        wide    = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {32'd0, req.sub};
        rsp.sum = wide[31:0];
        rsp.ge  = req.sub & wide[32];
    end

endmodule

>>> sv/sat_ctrl.sv
// ----------------------------------------------------------------------------
// Section translator sequencer
// Runs each lookup or conversion as a series of steps on the shared adder: table scan,
// bound checks, offset arithmetic and base conversions. Holds the response.
// ----------------------------------------------------------------------------
module sat_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sat_pkg::cfg_t                cfg,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [3:0]                   command,
    input  sat_pkg::sect_row_t           entry,
    input  logic [31:0]                  query_value,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [31:0]                  result_value,
    output logic                         table_full,
    // shared adder
    output sat_pkg::alu_req_t            alu_req,
    input  sat_pkg::alu_rsp_t            alu_rsp,
    // section table
    output logic                         ram_we,
    output logic [sat_pkg::IDX_W-1:0]    ram_waddr,
    output sat_pkg::sect_row_t           ram_wdata,
    output logic [sat_pkg::IDX_W-1:0]    ram_raddr,
    input  sat_pkg::sect_row_t           ram_rdata
);
    import sat_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_RD,
        ST_CMP,
        ST_END_ADD,
        ST_END_CMP,
        ST_RAW_ADD,
        ST_RAW_CMP,
        ST_DIFF,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_vld_reg, hit_vld_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [31:0]      result_reg, result_next;
    logic             table_full_reg, table_full_next;

    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [3:0]       cmd_reg, cmd_next;
    logic             by_load_reg, by_load_next;
    logic [31:0]      q_reg, q_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      res_reg, res_next;
    logic             full_reg, full_next;
    sect_row_t        hit_row_reg, hit_row_next;

    logic [31:0]      base;
    logic [31:0]      key_rd;
    logic [31:0]      key_hit;
    logic [31:0]      other_hit;
    logic [31:0]      miss_val;
    logic             base_add;

    // Operand selection
    assign base      = cfg.use_process_base ? cfg.process_base : cfg.image_base;
    assign key_rd    = by_load_reg ? ram_rdata.load_addr : ram_rdata.start;
    assign key_hit   = by_load_reg ? hit_row_reg.load_addr : hit_row_reg.start;
    assign other_hit = by_load_reg ? hit_row_reg.start :
                       ((cmd_reg == CMD_VA_TO_OFFSET) ? hit_row_reg.file_pos
                                                      : hit_row_reg.load_addr);
    // lookups by start return the query on a miss, lookups by load address 0
    assign miss_val  = by_load_reg ? 32'd0 : q_reg;
    assign base_add  = (cmd_reg == CMD_VA_TO_ABS) || (cmd_reg == CMD_ADDR_TO_ABS);

    // Table ports
    assign ram_waddr = cnt_reg[IDX_W-1:0];
    assign ram_wdata = entry;
    assign ram_raddr = scan_reg[IDX_W-1:0];

    // Shared adder operands per step
    always_comb
    begin
        alu_req.a   = q_reg;
        alu_req.b   = acc_reg;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            ST_BASE:
            begin
                alu_req.a   = base_add ? base : q_reg;
                alu_req.b   = base_add ? q_reg : base;
                alu_req.sub = !base_add;
            end
            ST_CMP:
            begin
                alu_req.b   = key_rd;
                alu_req.sub = 1'b1;
            end
            ST_END_ADD:
            begin
                alu_req.a = key_hit;
                alu_req.b = hit_row_reg.image_size;
            end
            ST_END_CMP, ST_RAW_CMP:
            begin
                alu_req.sub = 1'b1;
            end
            ST_RAW_ADD:
            begin
                alu_req.a = hit_row_reg.start;
                alu_req.b = hit_row_reg.raw_size;
            end
            ST_DIFF:
            begin
                alu_req.b   = key_hit;
                alu_req.sub = 1'b1;
            end
            ST_FIN:
            begin
                alu_req.a = acc_reg;
                alu_req.b = other_hit;
            end
            default:
            begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hit_vld_next    = hit_vld_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        result_next     = result_reg;
        table_full_next = table_full_reg;
        scan_next       = scan_reg;
        cmd_next        = cmd_reg;
        by_load_next    = by_load_reg;
        q_next          = q_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        full_next       = full_reg;
        hit_row_next    = hit_row_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next     = command;
                    q_next       = query_value;
                    res_next     = 32'd0;
                    full_next    = 1'b0;
                    scan_next    = '0;
                    hit_vld_next = 1'b0;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_OUT;
                        end
                        CMD_APPEND:
                        begin
                            if (cnt_reg >= SECT_MAX_CNT)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            state_next = ST_OUT;
                        end
                        CMD_VA_TO_OFFSET, CMD_VA_TO_ADDR:
                        begin
                            by_load_next = 1'b0;
                            res_next     = query_value;
                            state_next   = (cnt_reg == '0) ? ST_OUT : ST_RD;
                        end
                        CMD_ADDR_TO_VA, CMD_ADDR_TO_ABS:
                        begin
                            by_load_next = 1'b1;
                            state_next   = (cnt_reg == '0) ? ST_OUT : ST_RD;
                        end
                        CMD_VA_TO_ABS, CMD_ABS_TO_VA, CMD_ABS_TO_ADDR:
                        begin
                            state_next = ST_BASE;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            // base add, or base subtract with underflow to zero
            ST_BASE:
            begin
                state_next = ST_OUT;
                if (base_add)
                begin
                    res_next = alu_rsp.sum;
                end
                else if (!alu_rsp.ge || (alu_rsp.sum == 32'd0))
                begin
                    res_next = 32'd0;
                end
                else if (cmd_reg == CMD_ABS_TO_VA)
                begin
                    res_next = alu_rsp.sum;
                end
                else
                begin
                    // absolute to load address: continue with a lookup by start
                    q_next       = alu_rsp.sum;
                    res_next     = alu_rsp.sum;
                    by_load_next = 1'b0;
                    scan_next    = '0;
                    hit_vld_next = 1'b0;
                    state_next   = (cnt_reg == '0) ? ST_OUT : ST_RD;
                end
            end

            ST_RD:
            begin
                state_next = ST_CMP;
            end

            // keep the last entry whose key is not above the query
            ST_CMP:
            begin
                if (alu_rsp.ge)
                begin
                    hit_row_next = ram_rdata;
                    hit_vld_next = 1'b1;
                    scan_next    = scan_reg + CNT_W'(1);
                    state_next   = (scan_next == cnt_reg) ? ST_END_ADD : ST_RD;
                end
                else if (hit_vld_reg)
                begin
                    state_next = ST_END_ADD;
                end
                else
                begin
                    res_next   = miss_val;
                    state_next = ST_OUT;
                end
            end

            ST_END_ADD:
            begin
                acc_next   = alu_rsp.sum;
                state_next = ST_END_CMP;
            end

            // outside the image size counts as a miss
            ST_END_CMP:
            begin
                if (alu_rsp.ge)
                begin
                    res_next   = miss_val;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = (cmd_reg == CMD_VA_TO_OFFSET) ? ST_RAW_ADD : ST_DIFF;
                end
            end

            ST_RAW_ADD:
            begin
                acc_next   = alu_rsp.sum;
                state_next = ST_RAW_CMP;
            end

            // past the raw data gives offset zero
            ST_RAW_CMP:
            begin
                if (alu_rsp.ge)
                begin
                    res_next   = 32'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end

            ST_DIFF:
            begin
                acc_next   = alu_rsp.sum;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                state_next = ST_OUT;
                if (cmd_reg != CMD_ADDR_TO_ABS)
                begin
                    res_next = alu_rsp.sum;
                end
                else if (alu_rsp.sum == 32'd0)
                begin
                    res_next = 32'd0;
                end
                else
                begin
                    q_next     = alu_rsp.sum;
                    state_next = ST_BASE;
                end
            end

            // hand over to the response register once it is free
            ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    result_next     = res_reg;
                    table_full_next = full_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            hit_vld_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            result_reg     <= 32'd0;
            table_full_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hit_vld_reg    <= hit_vld_next;
            rsp_valid_reg  <= rsp_valid_next;
            result_reg     <= result_next;
            table_full_reg <= table_full_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        cmd_reg     <= cmd_next;
        by_load_reg <= by_load_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        full_reg    <= full_next;
        hit_row_reg <= hit_row_next;
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign result_value = result_reg;
    assign table_full   = table_full_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SECT_MAX_CNT)
        else $error("section count beyond table size");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cnt_reg < SECT_MAX_CNT))
        else $error("table write with no free entry");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (scan_reg < cnt_reg))
        else $error("scan past last valid entry");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted request not processed");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("response raised outside hand-over step");

endmodule

>>> sv/section_address_translator.sv
// ----------------------------------------------------------------------------
// Section address translator
// Translates 32-bit addresses through a table of up to SECT_MAX sections,
// which must be appended in ascending start order by the user; the block
// itself does not enforce this. One request is handled at a time; the block
// stalls requests while busy. Clear, append, unused commands and lookups on
// an empty table go straight to the response. A table lookup reads and
// compares one entry at a time, then checks the image size bound (and the
// raw size bound for file offsets) and forms the result. The two combined
// conversions run a base conversion and a lookup in turn. The steps follow
// from the single shared 32-bit adder and the registered read data of the
// section table RAM. A finished response waits in an output register while
// the next request is taken.
// Configuration registers sit on the APB port at byte addresses 0x0
// (image base), 0x4 (process base) and 0x8 (process base select).
// ----------------------------------------------------------------------------
module section_address_translator (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sat_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [3:0]                    command,
    input  logic [31:0]                   entry_start,
    input  logic [31:0]                   entry_file_pos,
    input  logic [31:0]                   entry_image_size,
    input  logic [31:0]                   entry_raw_size,
    input  logic [31:0]                   entry_load_addr,
    input  logic [31:0]                   query_value,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [31:0]                   result_value,
    output logic                          table_full
);
    import sat_pkg::*;

    logic [31:0] image_base_reg;
    logic [31:0] process_base_reg;
    logic        use_process_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    cfg_t        cfg;
    sect_row_t   entry;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic        ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    sect_row_t   ram_wdata;
    sect_row_t   ram_rdata;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_base_reg   <= 32'd0;
            process_base_reg <= 32'd0;
            use_process_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_IMAGE_BASE:   image_base_reg   <= pwdata;
                REG_PROCESS_BASE: process_base_reg <= pwdata;
                REG_USE_PROCESS:  use_process_reg  <= pwdata[0];
                default:          use_process_reg  <= use_process_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_BASE:   prdata = image_base_reg;
            REG_PROCESS_BASE: prdata = process_base_reg;
            REG_USE_PROCESS:  prdata = {31'd0, use_process_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.image_base       = image_base_reg;
    assign cfg.process_base     = process_base_reg;
    assign cfg.use_process_base = use_process_reg;

    // Append payload as one table row
    assign entry.start      = entry_start;
    assign entry.file_pos   = entry_file_pos;
    assign entry.image_size = entry_image_size;
    assign entry.raw_size   = entry_raw_size;
    assign entry.load_addr  = entry_load_addr;

    // Section table
    sat_ram #(
        .WIDTH ($bits(sect_row_t)),
        .DEPTH (SECT_MAX)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared adder
    sat_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Sequencer
    sat_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .entry        (entry),
        .query_value  (query_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .table_full   (table_full),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

endmodule
